### hw/rtl/sudc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Settable clock package
// This file holds the types, widths, reset values and key codes that the
// settable up/down clock modules share.
// ----------------------------------------------------------------------------
package sudc_pkg;

   localparam int DivideWidth = 16;
   localparam int HourWidth   = 5;
   localparam int MinSecWidth = 6;
   localparam int EditWidth   = 3;
   localparam int ModeWidth   = 4;
   localparam int KeyWidth    = 5;
   localparam int ReqDataBits = 8;
   localparam int RspDataBits = 32;

   localparam logic [DivideWidth-1:0] DivideReset = 16'd700;

   localparam logic [HourWidth-1:0]   HourReset   = 5'd23;
   localparam logic [MinSecWidth-1:0] MinuteReset = 6'd59;
   localparam logic [MinSecWidth-1:0] SecondReset = 6'd56;

   localparam logic [HourWidth-1:0]   HourMax   = 5'd23;
   localparam logic [MinSecWidth-1:0] MinSecMax = 6'd59;
   localparam logic [EditWidth-1:0]   EditLast  = 3'd6;
   localparam logic [EditWidth-1:0]   EditFirst = 3'd1;
   localparam logic [EditWidth-1:0]   EditNone  = 3'd0;

   localparam logic [ModeWidth-1:0] ModeDigitZero = 4'd0;
   localparam logic [ModeWidth-1:0] ModeDigitEnd  = 4'd10;
   localparam logic [ModeWidth-1:0] ModeCountUp   = 4'd11;
   localparam logic [ModeWidth-1:0] ModeCountDown = 4'd12;
   localparam logic [ModeWidth-1:0] ModeClear     = 4'd13;

   localparam logic [KeyWidth-1:0] KeyRunStop = 5'd10;
   localparam logic [KeyWidth-1:0] KeyEdit    = 5'd14;
   localparam logic [KeyWidth-1:0] KeyLastSet = 5'd15;
   localparam logic [KeyWidth-1:0] KeyZero    = 5'd16;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_KEY  = 1'b1;

   typedef struct packed {
      logic [HourWidth-1:0]   hours;
      logic [MinSecWidth-1:0] minutes;
      logic [MinSecWidth-1:0] seconds;
      logic                   running;
      logic [EditWidth-1:0]   edit_position;
      logic [ModeWidth-1:0]   mode_code;
      logic [DivideWidth-1:0] prescale;
   } clock_state_type;

endpackage

### hw/rtl/sudc_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Settable clock update logic
// Computes the clock state that follows one tick or one key event.
// ----------------------------------------------------------------------------
module sudc_update (
   input  sudc_pkg::clock_state_type            cur_state,
   input  logic                                  req_type,
   input  logic [sudc_pkg::KeyWidth-1:0]         key,
   input  logic [sudc_pkg::DivideWidth-1:0]      second_divide,
   output sudc_pkg::clock_state_type             next_state
);
   import sudc_pkg::*;

   function automatic logic [2:0] tens_of(input logic [5:0] value);
      logic [2:0] t;
      if (value >= 6'd60) begin
         t = 3'd6;
      end else if (value >= 6'd50) begin
         t = 3'd5;
      end else if (value >= 6'd40) begin
         t = 3'd4;
      end else if (value >= 6'd30) begin
         t = 3'd3;
      end else if (value >= 6'd20) begin
         t = 3'd2;
      end else if (value >= 6'd10) begin
         t = 3'd1;
      end else begin
         t = 3'd0;
      end
      return t;
   endfunction

   function automatic logic [6:0] put_digit(input logic [5:0] value, input logic [3:0] digit,
                                           input logic tens);
      logic [2:0] t;
      logic [6:0] t10;
      logic [6:0] units;
      logic [6:0] d10;
      t     = tens_of(value);
      t10   = {1'b0, t, 3'b000} + {3'b000, t, 1'b0};
      units = {1'b0, value} - t10;
      d10   = {digit, 3'b000} + {2'b00, digit, 1'b0};
      if (tens) begin
         return units + d10;
      end
      return t10 + {3'b000, digit};
   endfunction

   logic [DivideWidth:0] prescale_inc;
   logic                 second_hit;
   logic [2:0]           pos;
   logic [6:0]           h_edit;
   logic [6:0]           m_edit;
   logic [6:0]           s_edit;
   logic                 digit_write;

   assign prescale_inc = {1'b0, cur_state.prescale} + 1'b1;
   assign second_hit   = prescale_inc >= {1'b0, second_divide};

   always_comb begin
      next_state  = cur_state;
      pos         = cur_state.edit_position;
      h_edit      = {2'b00, cur_state.hours};
      m_edit      = {1'b0, cur_state.minutes};
      s_edit      = {1'b0, cur_state.seconds};
      digit_write = 1'b0;
      if (req_type == REQ_TICK) begin
         next_state.prescale = second_hit ? '0 : prescale_inc[DivideWidth-1:0];
         if (second_hit && cur_state.running) begin
            case (cur_state.mode_code)
               ModeCountUp: begin
                  if (cur_state.seconds >= MinSecMax) begin
                     next_state.seconds = '0;
                     if (cur_state.minutes >= MinSecMax) begin
                        next_state.minutes = '0;
                        next_state.hours   = (cur_state.hours >= HourMax) ? '0 :
                                             cur_state.hours + 1'b1;
                     end else begin
                        next_state.minutes = cur_state.minutes + 1'b1;
                     end
                  end else begin
                     next_state.seconds = cur_state.seconds + 1'b1;
                  end
               end
               ModeCountDown: begin
                  if (cur_state.seconds == '0) begin
                     next_state.seconds = MinSecMax;
                     if (cur_state.minutes == '0) begin
                        next_state.minutes = MinSecMax;
                        next_state.hours   = (cur_state.hours == '0) ? HourMax :
                                             cur_state.hours - 1'b1;
                     end else begin
                        next_state.minutes = cur_state.minutes - 1'b1;
                     end
                  end else begin
                     next_state.seconds = cur_state.seconds - 1'b1;
                  end
               end
               ModeClear: begin
                  next_state.hours   = '0;
                  next_state.minutes = '0;
                  next_state.seconds = '0;
               end
               default: begin
               end
            endcase
         end
      end else begin
         if (key inside {[5'd1:5'd9], [5'd11:KeyLastSet]}) begin
            next_state.mode_code = key[ModeWidth-1:0];
         end else if (key == KeyZero) begin
            next_state.mode_code = ModeDigitZero;
         end
         if (key == KeyRunStop) begin
            next_state.running = ~cur_state.running;
         end
         if (!next_state.running) begin
            if (key == KeyEdit) begin
               pos = (cur_state.edit_position >= EditLast) ? EditFirst :
                     cur_state.edit_position + 1'b1;
               next_state.edit_position = pos;
            end
            digit_write = (next_state.mode_code < ModeDigitEnd) && (pos != EditNone) &&
                          (pos <= EditLast);
            if (digit_write) begin
               if (pos <= 3'd2) begin
                  h_edit = put_digit({1'b0, cur_state.hours}, next_state.mode_code, pos[0]);
               end else if (pos <= 3'd4) begin
                  m_edit = put_digit(cur_state.minutes, next_state.mode_code, pos[0]);
               end else begin
                  s_edit = put_digit(cur_state.seconds, next_state.mode_code, pos[0]);
               end
            end
            if (h_edit > {2'b00, HourMax}) begin
               next_state.hours     = '0;
               next_state.mode_code = ModeDigitZero;
            end else begin
               next_state.hours = h_edit[HourWidth-1:0];
            end
            next_state.minutes = (m_edit > {1'b0, MinSecMax}) ? '0 : m_edit[MinSecWidth-1:0];
            next_state.seconds = (s_edit > {1'b0, MinSecMax}) ? '0 : s_edit[MinSecWidth-1:0];
         end
      end
   end

endmodule

### hw/rtl/settable_up_down_clock_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Settable up/down clock
// A 24-hour clock with a tick prescaler, run/stop and key-driven editing.
//
//   Channel  Direction  Payload
//   req_     in         tuser: req_type; tdata[4:0]: key
//   rsp_     out        tdata: hours, minutes, seconds, running, edit_position,
//                       mode_code (from bit 0 up)
//   csr_     in         data: second_divide
//
// Each transfer is registered in the input register, then updates the state and
// yields one result transfer through the result register; one item is taken every
// cycle while the result is not stalled.
// Synchronous reset sets the time to 23:59:56, stopped, mode 0, prescaler 0.
// A stalled result holds the input register, and req_tready falls only when
// both registers are full.
// ----------------------------------------------------------------------------
module settable_up_down_clock_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,   // req_type
   input  logic [sudc_pkg::ReqDataBits-1:0]    req_tdata,   // key [4:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sudc_pkg::RspDataBits-1:0]    rsp_tdata,   // hours, minutes, seconds,
                                                            // running, edit_position,
                                                            // mode_code
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sudc_pkg::DivideWidth-1:0]    csr_data     // second_divide
);
   import sudc_pkg::*;

   logic                    in_valid_ff, in_valid_in;
   logic                    in_type_ff;
   logic [KeyWidth-1:0]     in_key_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RspDataBits-1:0]  rsp_data_ff;
   logic [DivideWidth-1:0]  divide_ff;
   clock_state_type         state_ff, state_in;
   logic                    advance;
   logic                    req_accept;
   logic                    fire;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign fire       = in_valid_ff && advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   sudc_update u_update (
      .cur_state     (state_ff),
      .req_type      (in_type_ff),
      .key           (in_key_ff),
      .second_divide (divide_ff),
      .next_state    (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         divide_ff              <= DivideReset;
         state_ff.hours         <= HourReset;
         state_ff.minutes       <= MinuteReset;
         state_ff.seconds       <= SecondReset;
         state_ff.running       <= 1'b0;
         state_ff.edit_position <= EditNone;
         state_ff.mode_code     <= ModeDigitZero;
         state_ff.prescale      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            divide_ff <= csr_data;
         end
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_type_ff <= req_tuser;
         in_key_ff  <= req_tdata[KeyWidth-1:0];
      end
      if (fire) begin
         rsp_data_ff <= {7'd0, state_in.mode_code, state_in.edit_position, state_in.running,
                         state_in.seconds, state_in.minutes, state_in.hours};
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("Input side stalled while the result register was empty.");

   assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("A processed transfer did not produce a result.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] <= HourMax) && (rsp_tdata[10:5] <= MinSecMax) &&
                     (rsp_tdata[16:11] <= MinSecMax))
      else $error("Time field out of range.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[20:18] <= EditLast)
      else $error("Edit position out of range.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(state_ff))
      else $error("State changed while the result was stalled.");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Settable up/down clock testbench
// Drives tick and key transfers into the clock with random gaps and a long
// result stall. A scoreboard class holds its own model of the time, run flag,
// edit position, sticky mode and prescaler. It predicts every result and
// checks the fields in order. The second divide register is reprogrammed
// between phases while the block is idle, covering both extremes.
// ----------------------------------------------------------------------------
module tb;
   import sudc_pkg::*;

   localparam logic [KeyWidth-1:0]  KeyNone       = 5'd0;
   localparam logic [KeyWidth-1:0]  KeyCountUp    = 5'd11;
   localparam logic [KeyWidth-1:0]  KeyCountDown  = 5'd12;
   localparam logic [KeyWidth-1:0]  KeyClear      = 5'd13;
   localparam logic [KeyWidth-1:0]  KeyMax        = 5'd31;
   localparam logic [EditWidth-1:0] EditHourUnits = 3'd2;
   localparam logic [EditWidth-1:0] EditMinUnits  = 3'd4;
   localparam int                   HoldCycles    = 300;
   localparam int                   PhaseItems    = 245;

   typedef struct packed {
      logic [ModeWidth-1:0]   mode_code;
      logic [EditWidth-1:0]   edit_position;
      logic                   running;
      logic [MinSecWidth-1:0] seconds;
      logic [MinSecWidth-1:0] minutes;
      logic [HourWidth-1:0]   hours;
   } clock_reading_type;

   class clock_scoreboard;
      bit [DivideWidth-1:0] divide;
      bit [HourWidth-1:0]   hour;
      bit [MinSecWidth-1:0] minute;
      bit [MinSecWidth-1:0] second;
      bit                   run;
      bit [EditWidth-1:0]   edit_pos;
      bit [ModeWidth-1:0]   mode;
      bit [DivideWidth-1:0] prescale;
      clock_reading_type    expected_reading[$];
      int                   errors;
      int                   checked;
      int                   seconds_counted;

      function new();
         divide   = DivideReset;
         hour     = HourReset;
         minute   = MinuteReset;
         second   = SecondReset;
         run      = 1'b0;
         edit_pos = EditNone;
         mode     = ModeDigitZero;
         prescale = '0;
      endfunction

      function void set_divide(bit [DivideWidth-1:0] value);
         divide = value;
      endfunction

      function int pending();
         return expected_reading.size();
      endfunction

      function void advance_second();
         seconds_counted++;
         if (mode == ModeCountUp) begin
            if (second >= MinSecMax) begin
               second = '0;
               if (minute >= MinSecMax) begin
                  minute = '0;
                  hour = (hour >= HourMax) ? '0 : hour + 5'd1;
               end else begin
                  minute = minute + 6'd1;
               end
            end else begin
               second = second + 6'd1;
            end
         end else if (mode == ModeCountDown) begin
            if (second == 0) begin
               second = MinSecMax;
               if (minute == 0) begin
                  minute = MinSecMax;
                  hour = (hour == 0) ? HourMax : hour - 5'd1;
               end else begin
                  minute = minute - 6'd1;
               end
            end else begin
               second = second - 6'd1;
            end
         end else if (mode == ModeClear) begin
            hour   = '0;
            minute = '0;
            second = '0;
         end
      endfunction

      function int put_digit(int value, int digit, bit tens);
         if (tens) return value % 10 + digit * 10;
         return value / 10 * 10 + digit;
      endfunction

      function void edit_time(bit [KeyWidth-1:0] key);
         int h;
         int m;
         int s;
         bit [EditWidth-1:0] pos;
         h   = hour;
         m   = minute;
         s   = second;
         pos = edit_pos;
         if (key == KeyEdit) begin
            pos = (pos >= EditLast) ? EditFirst : pos + 3'd1;
            edit_pos = pos;
         end
         if (mode < ModeDigitEnd && pos >= EditFirst && pos <= EditLast) begin
            if (pos <= EditHourUnits)     h = put_digit(h, mode, pos[0]);
            else if (pos <= EditMinUnits) m = put_digit(m, mode, pos[0]);
            else                          s = put_digit(s, mode, pos[0]);
         end
         if (h > HourMax) begin
            h = 0;
            mode = ModeDigitZero;
         end
         if (m > MinSecMax) m = 0;
         if (s > MinSecMax) s = 0;
         hour   = h[HourWidth-1:0];
         minute = m[MinSecWidth-1:0];
         second = s[MinSecWidth-1:0];
      endfunction

      function void note_transfer(bit kind, bit [KeyWidth-1:0] key);
         int unsigned next_count;
         clock_reading_type reading;
         if (kind == REQ_TICK) begin
            next_count = prescale + 1;
            if (next_count >= divide) begin
               prescale = '0;
               if (run) advance_second();
            end else begin
               prescale = next_count[DivideWidth-1:0];
            end
         end else begin
            if (key inside {[5'd1:5'd9], [KeyCountUp:KeyLastSet]})
               mode = key[ModeWidth-1:0];
            else if (key == KeyZero)
               mode = ModeDigitZero;
            if (key == KeyRunStop) run = ~run;
            if (!run) edit_time(key);
         end
         reading.hours         = hour;
         reading.minutes       = minute;
         reading.seconds       = second;
         reading.running       = run;
         reading.edit_position = edit_pos;
         reading.mode_code     = mode;
         expected_reading.push_back(reading);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_transfer(logic [RspDataBits-1:0] data);
         clock_reading_type want;
         clock_reading_type got;
         if (expected_reading.size() == 0) begin
            $error("result transfer with no prediction pending: %h", data);
            errors++;
            return;
         end
         want = expected_reading.pop_front();
         got  = clock_reading_type'(data[$bits(clock_reading_type)-1:0]);
         checked++;
         compare_field("hours", want.hours, got.hours);
         compare_field("minutes", want.minutes, got.minutes);
         compare_field("seconds", want.seconds, got.seconds);
         compare_field("running", want.running, got.running);
         compare_field("edit_position", want.edit_position, got.edit_position);
         compare_field("mode_code", want.mode_code, got.mode_code);
         compare_field("padding", 0, data[RspDataBits-1:$bits(clock_reading_type)]);
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic                   req_tuser  = REQ_TICK;
   logic [ReqDataBits-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [DivideWidth-1:0] csr_data   = '0;

   clock_scoreboard sb = new();

   bit                 sender_idle   = 1'b1;
   bit                 receiver_idle = 1'b1;
   bit                 hold_request  = 1'b0;
   bit                 shadow_run    = 1'b0;
   bit [EditWidth-1:0] shadow_pos    = EditNone;
   int                 counted_items;
   int                 total_items;
   int                 settings_used = 1;

   settable_up_down_clock_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_transfer(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_transfer(req_tuser, req_tdata[KeyWidth-1:0]);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (receiver_idle && $urandom_range(0, 99) < 25) begin
            rsp_tready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic drive_item(input logic kind, input logic [KeyWidth-1:0] key);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(ReqDataBits-KeyWidth){1'b0}}, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      total_items++;
      if (kind == REQ_TICK || (key != KeyNone && key <= KeyZero)) counted_items++;
      if (kind == REQ_KEY) begin
         if (key == KeyRunStop) shadow_run = ~shadow_run;
         if (!shadow_run && key == KeyEdit)
            shadow_pos = (shadow_pos >= EditLast) ? EditFirst : shadow_pos + 3'd1;
      end
      if (sender_idle && !hold_request && $urandom_range(0, 1) == 1) begin
         req_tvalid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   task automatic drain();
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic program_divide(input logic [DivideWidth-1:0] value);
      req_tvalid <= 1'b0;
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_divide(value);
      settings_used++;
   endtask

   function automatic logic [KeyWidth-1:0] key_for(int digit);
      return (digit == 0) ? KeyZero : digit[KeyWidth-1:0];
   endfunction

   function automatic logic [KeyWidth-1:0] random_digit_key();
      return key_for(($urandom_range(0, 9) < 3) ? 9 : $urandom_range(0, 9));
   endfunction

   task automatic stop_clock();
      if (shadow_run) drive_item(REQ_KEY, KeyRunStop);
   endtask

   task automatic preset_episode();
      int target[6];
      int choice;
      choice = $urandom_range(0, 2);
      if (choice == 0)      target = '{2, 3, 5, 9, 5, $urandom_range(0, 9)};
      else if (choice == 1) target = '{0, 0, 0, 0, 0, $urandom_range(0, 9)};
      else target = '{$urandom_range(0, 2), $urandom_range(0, 9), $urandom_range(0, 5),
                      $urandom_range(0, 9), $urandom_range(0, 5), $urandom_range(0, 9)};
      stop_clock();
      while (shadow_pos != EditLast) drive_item(REQ_KEY, KeyEdit);
      for (int i = 0; i < 7; i++) begin
         drive_item(REQ_KEY, KeyEdit);
         drive_item(REQ_KEY, key_for(target[i % 6]));
      end
   endtask

   task automatic edit_episode();
      stop_clock();
      repeat ($urandom_range(1, 4)) begin
         repeat ($urandom_range(1, 3)) drive_item(REQ_KEY, KeyEdit);
         drive_item(REQ_KEY, random_digit_key());
      end
   endtask

   task automatic noise_episode();
      repeat ($urandom_range(1, 6))
         drive_item(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
   endtask

   task automatic count_episode();
      int r;
      if (!shadow_run) drive_item(REQ_KEY, KeyRunStop);
      r = $urandom_range(0, 19);
      drive_item(REQ_KEY, (r < 9) ? KeyCountUp : (r < 18) ? KeyCountDown : KeyClear);
      repeat ($urandom_range(5, 60)) begin
         if ($urandom_range(0, 99) < 8) drive_item(REQ_KEY, 5'($urandom_range(0, 31)));
         else drive_item(REQ_TICK, 5'($urandom_range(0, 31)));
      end
   endtask

   task automatic random_phase();
      int r;
      counted_items = 0;
      while (counted_items < PhaseItems) begin
         r = $urandom_range(0, 99);
         if (r < 20)      preset_episode();
         else if (r < 45) edit_episode();
         else if (r < 85) count_episode();
         else             noise_episode();
      end
   endtask

   initial begin
      #15_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [DivideWidth-1:0] divides[8];
      divides = '{16'd1, 16'd2, 16'd65535, 16'd1, 16'd3,
                  16'($urandom_range(1, 12)), 16'($urandom_range(1, 65535)), DivideReset};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      drive_item(REQ_KEY, KeyNone);
      drive_item(REQ_KEY, KeyMax);
      drive_item(REQ_KEY, 5'd17);
      drive_item(REQ_KEY, 5'd5);
      drive_item(REQ_KEY, KeyEdit);
      drive_item(REQ_KEY, 5'd2);
      drive_item(REQ_KEY, KeyEdit);
      drive_item(REQ_KEY, 5'd9);
      drive_item(REQ_KEY, KeyEdit);
      drive_item(REQ_KEY, 5'd9);
      drive_item(REQ_KEY, KeyEdit);
      drive_item(REQ_KEY, KeyZero);
      drive_item(REQ_KEY, KeyEdit);
      drive_item(REQ_KEY, 5'd7);
      drive_item(REQ_KEY, KeyEdit);
      drive_item(REQ_KEY, 5'd8);
      drive_item(REQ_KEY, KeyEdit);
      drive_item(REQ_TICK, KeyMax);
      drive_item(REQ_KEY, KeyRunStop);
      drive_item(REQ_KEY, KeyCountDown);
      drive_item(REQ_TICK, KeyNone);
      drive_item(REQ_KEY, KeyCountUp);
      drive_item(REQ_KEY, KeyClear);
      drive_item(REQ_KEY, KeyLastSet);
      drive_item(REQ_KEY, KeyEdit);
      drive_item(REQ_KEY, KeyRunStop);
      drive_item(REQ_TICK, KeyNone);

      for (int p = 0; p < 8; p++) begin
         program_divide(divides[p]);
         sender_idle   = (p != 4);
         receiver_idle = (p != 4);
         if (p == 1) hold_request = 1'b1;
         random_phase();
      end

      req_tvalid <= 1'b0;
      drain();
      $display("Covered %0d input transfers over %0d divide settings, %0d seconds counted.",
               total_items, settings_used, sb.seconds_counted);
      $display("Checked %0d result transfers, %0d mismatches.", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
